// ===== design/bencode_stream_parser_top_assert.svh =====
// Assertion macros shared by the bencode stream parser
`ifndef BENCODE_STREAM_PARSER_TOP_ASSERT_SVH
`define BENCODE_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bsp_pkg.sv =====
// Types and constants for the bencode stream parser
package bsp_pkg;

  localparam int NEST_DEPTH = 32;
  localparam int LVL_W      = $clog2(NEST_DEPTH + 1);
  localparam int STK_AW     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int POS_W      = 32;
  localparam int STR_LEN_MAX_DIGITS = 19;

  typedef enum logic [2:0] {
    M_ITEM, M_INT_FIRST, M_INT_MINUS, M_INT_DIGITS, M_STR_LEN, M_STR_BODY, M_DONE, M_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    ENT_NONE = 2'd0, ENT_LIST = 2'd1, ENT_KEY = 2'd2, ENT_VAL = 2'd3
  } ent_t;

  typedef enum logic [3:0] {
    EV_NONE = 4'd0, EV_INT = 4'd1, EV_STR_HDR = 4'd2, EV_STR_BYTE = 4'd3, EV_STR_DONE = 4'd4,
    EV_LIST = 4'd5, EV_DICT = 4'd6, EV_CLOSE = 4'd7, EV_ERROR = 4'd8
  } evt_t;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_EMPTY = 4'd1, ERR_MISSING = 4'd2, ERR_BAD_TYPE = 4'd3,
    ERR_NEG_ZERO = 4'd4, ERR_LEAD_ZERO = 4'd5, ERR_NON_DIGIT = 4'd6, ERR_BOUNDS = 4'd7,
    ERR_NO_E = 4'd8, ERR_NO_COLON = 4'd9, ERR_STR_EOF = 4'd10, ERR_KEY_NOT_STR = 4'd11,
    ERR_TOO_DEEP = 4'd12
  } err_t;

  localparam logic [7:0] CH_E = 8'h65, CH_MINUS = 8'h2d, CH_I = 8'h69, CH_L = 8'h6c;
  localparam logic [7:0] CH_D = 8'h64, CH_COLON = 8'h3a, CH_0 = 8'h30, CH_9 = 8'h39;

  localparam logic [63:0] S64_TOP = 64'h7fff_ffff_ffff_ffff;

  // stack write/read port between core and memory
  typedef struct packed {
    logic              wr_en;
    logic [STK_AW-1:0] wr_addr;
    ent_t              wr_data;
    logic [STK_AW-1:0] rd_addr;
  } stk_req_t;

  // letters of the key "info", indexed by match progress
  function automatic logic [7:0] info_char(input logic [2:0] idx);
    unique case (idx)
      3'd1:    info_char = 8'h69;
      3'd2:    info_char = 8'h6e;
      3'd3:    info_char = 8'h66;
      3'd4:    info_char = 8'h6f;
      default: info_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== design/bsp_stack.sv =====
// Nesting stack memory: entries below the cached top, with a registered read
module bsp_stack
  import bsp_pkg::*;
(
  input  logic     clk,
  input  stk_req_t req,
  output ent_t     rd_data
);

  ent_t mem [NEST_DEPTH];
  ent_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read, same-cycle write forwarded
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/bencode_stream_parser_top.sv =====
// Bencode stream parser top level: parse control, stack and result register
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_op in_data_byte    | sink
//  out     | out_valid out_ready out_event_res .. etc | source
//
// One word per clock sustained while the output is not stalled; each input word yields one registered result word.
// The nesting stack sits in a memory with a registered read; the top entry is held in a register and
// the entry below is prefetched every cycle, with write-to-read forwarding.
// Reset (rst_n low, synchronous) clears all control state; stack contents are not cleared.
// An output stall holds the result register and drops in_ready until it is taken.
module bencode_stream_parser_top
  import bsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_event_res,
  output logic signed [63:0] out_int_value,
  output logic [63:0]        out_string_length,
  output logic [7:0]         out_payload_byte,
  output logic [5:0]         out_nest_depth,
  output logic               out_is_dict_key,
  output logic [3:0]         out_error_code,
  output logic               out_root_done,
  output logic               out_info_valid,
  output logic [31:0]        out_info_start,
  output logic [31:0]        out_info_length
);

  `include "bencode_stream_parser_top_assert.svh"

  // parse state
  mode_t             mode_r, mode_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic              zp_r, zp_nxt;
  logic [4:0]        ldc_r, ldc_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  ent_t              top_r, top_nxt;
  logic [2:0]        km_r, km_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  istart_r, istart_nxt;
  logic              iseen_r, iseen_nxt;
  logic [31:0]       ispan_r, ispan_nxt;
  err_t              err_r, err_nxt;
  logic              ipend_r, ipend_nxt;
  logic [LVL_W-1:0]  ilvl_r, ilvl_nxt;

  // result register
  logic              ovalid_r;
  evt_t              oev_r;
  logic [63:0]       oint_r, olen_r;
  logic [7:0]        obyte_r;
  logic              okey_r;

  evt_t              ev;
  logic [63:0]       ev_int, ev_len;
  logic [7:0]        ev_byte;
  logic              ev_key;

  logic              step;
  logic              do_err, do_done, popped;
  err_t              err_code;
  ent_t              top_cur, t_eff, below;
  logic              is_dig;
  logic [3:0]        dval;
  logic [POS_W-1:0]  np;
  logic [67:0]       prod;
  logic [67:0]       lim;
  logic [LVL_W-1:0]  rd_lvl, wr_lvl;
  logic              stk_we;
  stk_req_t          stk_req;

  assign in_ready = !ovalid_r || out_ready;
  assign step     = in_valid && in_ready;

  assign top_cur = (lvl_r == '0) ? ENT_NONE : top_r;
  assign is_dig  = (in_data_byte >= CH_0) && (in_data_byte <= CH_9);
  assign dval    = in_data_byte[3:0];
  assign np      = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign prod    = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, dval};
  assign lim     = neg_r ? {4'd0, S64_TOP} + 68'd1 : {4'd0, S64_TOP};

  // stack port: push writes old top, prefetch reads the entry below the next top
  assign wr_lvl          = lvl_r - 1'b1;
  assign rd_lvl          = lvl_nxt - LVL_W'(2);
  assign stk_req.wr_en   = stk_we;
  assign stk_req.wr_addr = wr_lvl[STK_AW-1:0];
  assign stk_req.wr_data = top_r;
  assign stk_req.rd_addr = rd_lvl[STK_AW-1:0];

  bsp_stack u_stack (
    .clk     (clk),
    .req     (stk_req),
    .rd_data (below)
  );

  // next state and result for one word
  always_comb begin
    mode_nxt = mode_r;  acc_nxt = acc_r;  neg_nxt = neg_r;  zp_nxt = zp_r;
    ldc_nxt = ldc_r;  rem_nxt = rem_r;  lvl_nxt = lvl_r;  top_nxt = top_r;
    km_nxt = km_r;  pos_nxt = pos_r;  istart_nxt = istart_r;  iseen_nxt = iseen_r;
    ispan_nxt = ispan_r;  err_nxt = err_r;  ipend_nxt = ipend_r;  ilvl_nxt = ilvl_r;
    ev = EV_NONE;  ev_int = '0;  ev_len = '0;  ev_byte = '0;  ev_key = 1'b0;
    do_err = 1'b0;  err_code = ERR_NONE;  do_done = 1'b0;  popped = 1'b0;
    stk_we = 1'b0;
    t_eff = top_r;
    if (step) begin
      if (in_op) begin
        // end of buffer
        unique case (mode_r)
          M_ITEM: begin
            do_err = 1'b1;
            if (lvl_r == '0)            err_code = (pos_r == '0) ? ERR_EMPTY : ERR_MISSING;
            else if (top_cur == ENT_VAL) err_code = ERR_MISSING;
            else                         err_code = ERR_NO_E;
          end
          M_INT_FIRST, M_INT_MINUS: begin
            do_err = 1'b1;  err_code = ERR_NO_E;
          end
          M_INT_DIGITS: begin
            do_err = 1'b1;  err_code = zp_r ? ERR_LEAD_ZERO : ERR_NO_E;
          end
          M_STR_LEN: begin
            do_err = 1'b1;  err_code = ERR_NO_COLON;
          end
          M_STR_BODY: begin
            do_err = 1'b1;  err_code = ERR_STR_EOF;
          end
          default: ;
        endcase
      end else begin
        pos_nxt = np;
        unique case (mode_r)
          M_ITEM: begin
            priority if (in_data_byte == CH_E &&
                         (top_cur == ENT_LIST || top_cur == ENT_KEY)) begin
              lvl_nxt = lvl_r - 1'b1;
              popped  = 1'b1;
              if (ipend_r && ilvl_r > lvl_nxt) ipend_nxt = 1'b0;
              ev = EV_CLOSE;
              do_done = 1'b1;
            end else if (top_cur == ENT_KEY && !is_dig) begin
              do_err = 1'b1;  err_code = ERR_KEY_NOT_STR;
            end else if (in_data_byte == CH_I) begin
              neg_nxt = 1'b0;  zp_nxt = 1'b0;  acc_nxt = '0;  mode_nxt = M_INT_FIRST;
            end else if (in_data_byte == CH_L || in_data_byte == CH_D) begin
              if (lvl_r >= LVL_W'(NEST_DEPTH)) begin
                do_err = 1'b1;  err_code = ERR_TOO_DEEP;
              end else begin
                stk_we = (lvl_r != '0);
                top_nxt = (in_data_byte == CH_L) ? ENT_LIST : ENT_KEY;
                lvl_nxt = lvl_r + 1'b1;
                ev = (in_data_byte == CH_L) ? EV_LIST : EV_DICT;
              end
            end else if (is_dig) begin
              acc_nxt = {60'd0, dval};  ldc_nxt = 5'd1;  mode_nxt = M_STR_LEN;
            end else begin
              do_err = 1'b1;  err_code = ERR_BAD_TYPE;
            end
          end
          M_INT_FIRST, M_INT_MINUS: begin
            if (mode_r == M_INT_FIRST && in_data_byte == CH_MINUS) begin
              neg_nxt = 1'b1;  mode_nxt = M_INT_MINUS;
            end else if (is_dig) begin
              zp_nxt = (in_data_byte == CH_0);
              acc_nxt = {60'd0, dval};
              mode_nxt = M_INT_DIGITS;
            end else begin
              do_err = 1'b1;  err_code = ERR_NON_DIGIT;
            end
          end
          M_INT_DIGITS: begin
            priority if (zp_r) begin
              if (in_data_byte != CH_E) begin
                do_err = 1'b1;  err_code = ERR_LEAD_ZERO;
              end else if (neg_r) begin
                do_err = 1'b1;  err_code = ERR_NEG_ZERO;
              end else begin
                ev = EV_INT;  ev_int = acc_r;  do_done = 1'b1;
              end
            end else if (in_data_byte == CH_E) begin
              ev = EV_INT;  ev_int = neg_r ? 64'd0 - acc_r : acc_r;  do_done = 1'b1;
            end else if (!is_dig) begin
              do_err = 1'b1;  err_code = ERR_NON_DIGIT;
            end else if (prod > lim) begin
              do_err = 1'b1;  err_code = ERR_BOUNDS;
            end else begin
              acc_nxt = prod[63:0];
            end
          end
          M_STR_LEN: begin
            priority if (in_data_byte == CH_COLON) begin
              ev_key  = (top_cur == ENT_KEY);
              rem_nxt = acc_r;
              km_nxt  = (ev_key && acc_r == 64'd4) ? 3'd1 : 3'd0;
              if (acc_r == '0) begin
                ev = EV_STR_DONE;  do_done = 1'b1;  km_nxt = 3'd0;
              end else begin
                ev = EV_STR_HDR;  ev_len = acc_r;  mode_nxt = M_STR_BODY;
              end
            end else if (!is_dig) begin
              do_err = 1'b1;  err_code = ERR_NO_COLON;
            end else if (ldc_r >= 5'(STR_LEN_MAX_DIGITS)) begin
              do_err = 1'b1;  err_code = ERR_BOUNDS;
            end else begin
              acc_nxt = prod[63:0];
              ldc_nxt = ldc_r + 1'b1;
            end
          end
          M_STR_BODY: begin
            ev_key  = (top_cur == ENT_KEY);
            ev_byte = in_data_byte;
            if (ev_key && km_r >= 3'd1 && km_r <= 3'd4 && in_data_byte == info_char(km_r))
              km_nxt = km_r + 1'b1;
            else
              km_nxt = 3'd0;
            rem_nxt = rem_r - 1'b1;
            if (rem_nxt == '0) begin
              // string complete: arm capture of the value keyed "info"
              if (ev_key) begin
                if (km_nxt == 3'd5 && !iseen_r && !ipend_r) begin
                  ipend_nxt = 1'b1;  ilvl_nxt = lvl_r;  istart_nxt = np;
                end
                km_nxt = 3'd0;
              end
              ev = EV_STR_DONE;  do_done = 1'b1;
            end else begin
              ev = EV_STR_BYTE;
            end
          end
          default: ;
        endcase
      end

      // item completed: advance the enclosing container
      if (do_done) begin
        t_eff = popped ? below : top_r;
        top_nxt = t_eff;
        if (lvl_nxt == '0) begin
          mode_nxt = M_DONE;
        end else begin
          if (t_eff == ENT_KEY) begin
            top_nxt = ENT_VAL;
          end else if (t_eff == ENT_VAL) begin
            if (ipend_nxt && ilvl_nxt == lvl_nxt) begin
              ispan_nxt = 32'(np - istart_nxt);
              iseen_nxt = 1'b1;
              ipend_nxt = 1'b0;
            end
            top_nxt = ENT_KEY;
          end
          mode_nxt = M_ITEM;
        end
      end

      // first error latches; errors inside a key string report as a bad key
      if (do_err) begin
        err_nxt  = ((mode_r == M_STR_LEN || mode_r == M_STR_BODY) && top_cur == ENT_KEY)
                   ? ERR_KEY_NOT_STR : err_code;
        mode_nxt = M_ERROR;
        ev       = EV_ERROR;
        ev_key   = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_ITEM;  acc_r <= '0;  neg_r <= 1'b0;  zp_r <= 1'b0;  ldc_r <= '0;
      rem_r <= '0;  lvl_r <= '0;  top_r <= ENT_NONE;  km_r <= '0;  pos_r <= '0;
      istart_r <= '0;  iseen_r <= 1'b0;  ispan_r <= '0;  err_r <= ERR_NONE;
      ipend_r <= 1'b0;  ilvl_r <= '0;  ovalid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;  acc_r <= acc_nxt;  neg_r <= neg_nxt;  zp_r <= zp_nxt;
      ldc_r <= ldc_nxt;  rem_r <= rem_nxt;  lvl_r <= lvl_nxt;  top_r <= top_nxt;
      km_r <= km_nxt;  pos_r <= pos_nxt;  istart_r <= istart_nxt;  iseen_r <= iseen_nxt;
      ispan_r <= ispan_nxt;  err_r <= err_nxt;  ipend_r <= ipend_nxt;  ilvl_r <= ilvl_nxt;
      if (step)           ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (step) begin
      oev_r   <= ev;
      oint_r  <= ev_int;
      olen_r  <= ev_len;
      obyte_r <= ev_byte;
      okey_r  <= ev_key;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_event_res     = oev_r;
  assign out_int_value     = oint_r;
  assign out_string_length = olen_r;
  assign out_payload_byte  = obyte_r;
  assign out_nest_depth    = 6'(lvl_r);
  assign out_is_dict_key   = okey_r;
  assign out_error_code    = err_r;
  assign out_root_done     = (mode_r == M_DONE);
  assign out_info_valid    = iseen_r;
  assign out_info_start    = 32'(istart_r);
  assign out_info_length   = ispan_r;

  // checks
  `BSP_ASSERT_NOW(a_no_take_on_stall, ovalid_r && !out_ready, !in_ready, "input taken while result stalled")
  `BSP_ASSERT_NEXT(a_err_latched, err_r != ERR_NONE, $stable(err_r), "latched error changed")
  `BSP_ASSERT_NOW(a_depth_bound, 1'b1, lvl_r <= LVL_W'(NEST_DEPTH), "nesting level past depth")
  `BSP_ASSERT_NOW(a_push_room, stk_req.wr_en, lvl_r < LVL_W'(NEST_DEPTH) && step, "stack write without room")

endmodule

// ===== dv/bencode_stream_parser_top_tb.sv =====
// Self-checking testbench for the bencode stream parser: random documents against a predictor
module bencode_stream_parser_top_tb;
  import bsp_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_op;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_event_res;
  logic signed [63:0] out_int_value;
  logic [63:0]        out_string_length;
  logic [7:0]         out_payload_byte;
  logic [5:0]         out_nest_depth;
  logic               out_is_dict_key;
  logic [3:0]         out_error_code;
  logic               out_root_done;
  logic               out_info_valid;
  logic [31:0]        out_info_start;
  logic [31:0]        out_info_length;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } word_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [63:0] ival;
    logic [63:0] slen;
    logic [7:0]  pbyte;
    logic [5:0]  depth;
    logic        key;
    logic [3:0]  err;
    logic        done;
    logic        iv;
    logic [31:0] istart;
    logic [31:0] ilen;
  } parse_res_t;

  localparam logic [31:0] POS_SAT = 32'hffff_ffff;
  localparam logic        OP_BYTE = 1'b0;
  localparam logic        OP_END  = 1'b1;

  word_t      byte_q[$];
  parse_res_t parse_exp_q[$];
  int         words_total;
  int         words_taken;
  int         mismatches;
  int         tx_idle_pct;
  int         rx_idle_pct;
  logic       rx_hold;

  bencode_stream_parser_top u_dut (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- parser predictor ----------------
  mode_t       pm_mode;
  logic [63:0] pm_acc;
  logic        pm_neg;
  logic        pm_zero;
  int          pm_ldig;
  logic [63:0] pm_remain;
  ent_t        pm_stack[NEST_DEPTH];
  int          pm_level;
  int          pm_kmatch;
  logic [31:0] pm_pos;
  logic [31:0] pm_istart;
  logic        pm_iseen;
  logic [31:0] pm_ispan;
  logic [3:0]  pm_err;
  logic        pm_ipend;
  int          pm_ilevel;
  logic [3:0]  pm_ev;
  logic [63:0] pm_ev_int;
  logic [63:0] pm_ev_len;
  logic [7:0]  pm_ev_byte;
  logic        pm_ev_key;

  function automatic ent_t top_ent();
    return (pm_level == 0) ? ENT_NONE : pm_stack[pm_level-1];
  endfunction

  function automatic logic [31:0] pos_next();
    return (pm_pos == POS_SAT) ? POS_SAT : pm_pos + 32'd1;
  endfunction

  function automatic bit is_dig(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic void fail_parse(err_t code);
    err_t c;
    c = code;
    // errors inside a key string all become key-not-string
    if ((pm_mode == M_STR_LEN || pm_mode == M_STR_BODY) && top_ent() == ENT_KEY)
      c = ERR_KEY_NOT_STR;
    pm_err  = c;
    pm_mode = M_ERROR;
    pm_ev   = EV_ERROR;
  endfunction

  function automatic void finish_item();
    ent_t t;
    if (pm_level == 0) begin
      pm_mode = M_DONE;
      return;
    end
    t = pm_stack[pm_level-1];
    if (t == ENT_KEY) begin
      pm_stack[pm_level-1] = ENT_VAL;
    end else if (t == ENT_VAL) begin
      if (pm_ipend && pm_ilevel == pm_level) begin
        pm_ispan  = pos_next() - pm_istart;
        pm_iseen  = 1'b1;
        pm_ipend  = 1'b0;
      end
      pm_stack[pm_level-1] = ENT_KEY;
    end
    pm_mode = M_ITEM;
  endfunction

  function automatic void first_digit(logic [7:0] b);
    if (b == CH_0) begin
      pm_zero = 1'b1;
      pm_acc  = '0;
      pm_mode = M_INT_DIGITS;
    end else if (is_dig(b)) begin
      pm_acc  = 64'(b - CH_0);
      pm_mode = M_INT_DIGITS;
    end else begin
      fail_parse(ERR_NON_DIGIT);
    end
  endfunction

  function automatic void emit_int();
    pm_ev     = EV_INT;
    pm_ev_int = pm_neg ? 64'd0 - pm_acc : pm_acc;
    finish_item();
  endfunction

  function automatic void close_string();
    if (pm_ev_key) begin
      if (pm_kmatch == 5 && !pm_iseen && !pm_ipend) begin
        pm_ipend  = 1'b1;
        pm_ilevel = pm_level;
        pm_istart = pos_next();
      end
      pm_kmatch = 0;
    end
    pm_ev = EV_STR_DONE;
    finish_item();
  endfunction

  function automatic void item_byte(logic [7:0] b);
    ent_t t;
    t = top_ent();
    if (b == CH_E && (t == ENT_LIST || t == ENT_KEY)) begin
      pm_level--;
      if (pm_ipend && pm_ilevel > pm_level) pm_ipend = 1'b0;
      pm_ev = EV_CLOSE;
      finish_item();
    end else if (t == ENT_KEY && !is_dig(b)) begin
      fail_parse(ERR_KEY_NOT_STR);
    end else if (b == CH_I) begin
      pm_neg  = 1'b0;
      pm_zero = 1'b0;
      pm_acc  = '0;
      pm_mode = M_INT_FIRST;
    end else if (b == CH_L || b == CH_D) begin
      if (pm_level >= NEST_DEPTH) begin
        fail_parse(ERR_TOO_DEEP);
      end else begin
        pm_stack[pm_level] = (b == CH_L) ? ENT_LIST : ENT_KEY;
        pm_level++;
        pm_ev = (b == CH_L) ? EV_LIST : EV_DICT;
      end
    end else if (is_dig(b)) begin
      pm_acc  = 64'(b - CH_0);
      pm_ldig = 1;
      pm_mode = M_STR_LEN;
    end else begin
      fail_parse(ERR_BAD_TYPE);
    end
  endfunction

  function automatic void data_byte_step(logic [7:0] b);
    string       word;
    logic [63:0] d;
    logic [63:0] lim;
    word = "info";
    case (pm_mode)
      M_ITEM: item_byte(b);
      M_INT_FIRST: begin
        if (b == CH_MINUS) begin
          pm_neg  = 1'b1;
          pm_mode = M_INT_MINUS;
        end else begin
          first_digit(b);
        end
      end
      M_INT_MINUS: first_digit(b);
      M_INT_DIGITS: begin
        if (pm_zero) begin
          if (b != CH_E) fail_parse(ERR_LEAD_ZERO);
          else if (pm_neg) fail_parse(ERR_NEG_ZERO);
          else emit_int();
        end else if (b == CH_E) begin
          emit_int();
        end else if (!is_dig(b)) begin
          fail_parse(ERR_NON_DIGIT);
        end else begin
          d   = 64'(b - CH_0);
          lim = pm_neg ? S64_TOP + 64'd1 : S64_TOP;
          if (pm_acc > (lim - d) / 64'd10) fail_parse(ERR_BOUNDS);
          else pm_acc = pm_acc * 64'd10 + d;
        end
      end
      M_STR_LEN: begin
        if (b == CH_COLON) begin
          pm_ev_key = (top_ent() == ENT_KEY);
          pm_remain = pm_acc;
          pm_kmatch = (pm_ev_key && pm_acc == 64'd4) ? 1 : 0;
          if (pm_acc == 0) begin
            close_string();
          end else begin
            pm_ev     = EV_STR_HDR;
            pm_ev_len = pm_acc;
            pm_mode   = M_STR_BODY;
          end
        end else if (!is_dig(b)) begin
          fail_parse(ERR_NO_COLON);
        end else if (pm_ldig >= 19) begin
          fail_parse(ERR_BOUNDS);
        end else begin
          pm_acc = pm_acc * 64'd10 + 64'(b - CH_0);
          pm_ldig++;
        end
      end
      M_STR_BODY: begin
        pm_ev_key  = (top_ent() == ENT_KEY);
        pm_ev_byte = b;
        if (pm_ev_key && pm_kmatch >= 1 && pm_kmatch <= 4 && b == word[pm_kmatch-1])
          pm_kmatch++;
        else
          pm_kmatch = 0;
        pm_remain--;
        if (pm_remain == 0) close_string();
        else pm_ev = EV_STR_BYTE;
      end
      default: ;
    endcase
  endfunction

  function automatic void end_mark_step();
    case (pm_mode)
      M_ITEM: begin
        if (pm_level == 0) fail_parse(pm_pos == 0 ? ERR_EMPTY : ERR_MISSING);
        else if (top_ent() == ENT_VAL) fail_parse(ERR_MISSING);
        else fail_parse(ERR_NO_E);
      end
      M_INT_FIRST, M_INT_MINUS: fail_parse(ERR_NO_E);
      M_INT_DIGITS: fail_parse(pm_zero ? ERR_LEAD_ZERO : ERR_NO_E);
      M_STR_LEN:    fail_parse(ERR_NO_COLON);
      M_STR_BODY:   fail_parse(ERR_STR_EOF);
      default: ;
    endcase
  endfunction

  function automatic parse_res_t parse_word(word_t w);
    parse_res_t r;
    pm_ev      = EV_NONE;
    pm_ev_int  = '0;
    pm_ev_len  = '0;
    pm_ev_byte = '0;
    pm_ev_key  = 1'b0;
    if (w.op == OP_END) begin
      end_mark_step();
    end else begin
      data_byte_step(w.b);
      pm_pos = pos_next();
    end
    if (pm_ev != EV_STR_BYTE && pm_ev != EV_STR_DONE) pm_ev_byte = '0;
    if (pm_ev < EV_STR_HDR || pm_ev > EV_STR_DONE) pm_ev_key = 1'b0;
    r.ev     = pm_ev;
    r.ival   = pm_ev_int;
    r.slen   = pm_ev_len;
    r.pbyte  = pm_ev_byte;
    r.depth  = 6'(pm_level);
    r.key    = pm_ev_key;
    r.err    = pm_err;
    r.done   = (pm_mode == M_DONE);
    r.iv     = pm_iseen;
    r.istart = pm_istart;
    r.ilen   = pm_ispan;
    return r;
  endfunction

  // ---------------- document generation ----------------
  function automatic void push_text(string s);
    word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.op = OP_BYTE;
      w.b  = s[i];
      byte_q.push_back(w);
    end
  endfunction

  function automatic void push_end();
    word_t w;
    w.op = OP_END;
    w.b  = 8'($urandom_range(255));
    byte_q.push_back(w);
  endfunction

  function automatic void push_string(int len);
    word_t w;
    int    pad;
    // occasional leading zeros on the length
    pad = ($urandom_range(7) == 0) ? int'($urandom_range(3)) : 0;
    for (int i = 0; i < pad; i++) push_text("0");
    push_text($sformatf("%0d:", len));
    for (int i = 0; i < len; i++) begin
      w.op = OP_BYTE;
      w.b  = 8'($urandom_range(255));
      byte_q.push_back(w);
    end
  endfunction

  function automatic void push_int();
    logic [63:0] mag;
    bit          neg;
    neg = $urandom_range(2) == 0;
    case ($urandom_range(3))
      0:       mag = 64'($urandom_range(9));
      1:       mag = 64'($urandom_range(100000));
      2:       mag = {1'b0, 31'($urandom), 32'($urandom)};
      default: mag = S64_TOP - 64'($urandom_range(3));
    endcase
    if (mag == 0) neg = 1'b0;
    push_text($sformatf("i%s%0de", neg ? "-" : "", mag));
  endfunction

  // one random value at nesting level lvl (lvl containers already open)
  function automatic void push_value(int lvl);
    int kind;
    int n;
    kind = $urandom_range(9);
    if (lvl >= NEST_DEPTH) kind = 0;
    else if (lvl > 4 && kind >= 6) kind = kind - 6;
    case (kind)
      0, 1, 2: push_int();
      3, 4, 5: push_string($urandom_range(30) == 0 ? $urandom_range(300) : $urandom_range(8));
      6, 7: begin
        // list, occasionally a deep chain
        if ($urandom_range(15) == 0) begin
          n = $urandom_range(NEST_DEPTH - lvl);
          for (int i = 0; i < n; i++) push_text("l");
          push_int();
          for (int i = 0; i < n; i++) push_text("e");
        end else begin
          push_text("l");
          n = $urandom_range(3);
          for (int i = 0; i < n; i++) push_value(lvl + 1);
          push_text("e");
        end
      end
      default: begin
        push_text("d");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) push_text("4:info");
          else push_string($urandom_range(5));
          push_value(lvl + 1);
        end
        push_text("e");
      end
    endcase
  endfunction

  // how the root list ends: cleanly or with one chosen fault
  function automatic void push_ending();
    case ($urandom_range(18))
      0:  push_text("e");
      1:  push_text("i-0e");
      2:  push_text("i05e");
      3:  push_text("ie");
      4:  push_text("i12ae");
      5:  push_text("i99999999999999999999e");
      6:  push_text("i-9223372036854775809e");
      7:  begin push_text("i42"); push_end(); end
      8:  push_text("x");
      9:  push_end();
      10: push_text("12x");
      11: push_text("12345678901234567890:");
      12: begin push_text("5:ab"); push_end(); end
      13: push_text("di1ee");
      14: begin push_text("d1:a"); push_end(); end
      15: push_text("d1:ae");
      16: for (int i = 0; i < NEST_DEPTH; i++) push_text("l");
      17: begin push_text("i0"); push_end(); end
      default: begin push_text("d3:ab"); push_end(); end
    endcase
    // ignored tail
    push_text("i7e3:xyz");
    push_end();
  endfunction

  // ---------------- sender ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_op        <= 1'b0;
      in_data_byte <= '0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid     <= 1'b1;
        in_op        <= byte_q[0].op;
        in_data_byte <= byte_q[0].b;
        byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------- monitor and checker ----------------
  always @(posedge clk) begin
    parse_res_t want;
    parse_res_t got;
    word_t      w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_event_res, out_int_value, out_string_length, out_payload_byte,
               out_nest_depth, out_is_dict_key, out_error_code, out_root_done,
               out_info_valid, out_info_start, out_info_length};
        if (parse_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %p", got);
        end else begin
          want = parse_exp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        w.op = in_op;
        w.b  = in_data_byte;
        parse_exp_q.push_back(parse_word(w));
        words_taken++;
      end
    end
  end

  // ---------------- stimulus and phases ----------------
  initial begin
    rst_n       = 1'b0;
    rx_hold     = 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 80;
    words_taken = 0;
    mismatches  = 0;

    pm_mode   = M_ITEM;
    pm_acc    = '0;
    pm_neg    = 1'b0;
    pm_zero   = 1'b0;
    pm_ldig   = 0;
    pm_remain = '0;
    pm_level  = 0;
    pm_kmatch = 0;
    pm_pos    = '0;
    pm_istart = '0;
    pm_iseen  = 1'b0;
    pm_ispan  = '0;
    pm_err    = ERR_NONE;
    pm_ipend  = 1'b0;
    pm_ilevel = 0;
    foreach (pm_stack[i]) pm_stack[i] = ENT_NONE;

    // directed: int extremes, zero, empty string, padded length, info value
    push_text("li9223372036854775807ei-9223372036854775808ei0e0:0003:abc");
    push_text("d4:infoli1e2:xye1:kde4:infoi3ee");
    while (byte_q.size() < 1750) push_value(1);
    push_ending();
    words_total = byte_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_taken >= words_total / 3);
    @(posedge clk);
    tx_idle_pct <= 80;
    rx_idle_pct <= 23;
    wait (words_taken >= 2 * words_total / 3);
    @(posedge clk);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    // long receiver stall while the sender keeps offering words
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;

    wait (words_taken == words_total && parse_exp_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && parse_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
